// File: rtl/core/typed_value_stream_decoder_assert.svh
// Assertion macros shared by the typed value stream decoder RTL.
`ifndef TYPED_VALUE_STREAM_DECODER_ASSERT_SVH
`define TYPED_VALUE_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTH
`define TVSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TVSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  `TVSD_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define TVSD_ASSERT(lbl, prop, msg)
`define TVSD_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/tvsd_pkg.sv
// Package with the codes and constants of the typed value stream decoder.
package tvsd_pkg;

  localparam int LengthBitsDefault = 32;

  typedef enum logic [2:0] {
    KUnsigned = 3'd0,
    KSigned   = 3'd1,
    KF32      = 3'd2,
    KF64      = 3'd3,
    KBool     = 3'd4,
    KStrLen   = 3'd5,
    KStrByte  = 3'd6,
    KNan      = 3'd7
  } kind_e;

  localparam logic [3:0] FuncNumber = 4'd0;
  localparam logic [3:0] FuncString = 4'd1;
  localparam logic [3:0] FuncBool   = 4'd2;
  localparam logic [3:0] FuncInt8   = 4'd3;
  localparam logic [3:0] FuncUint8  = 4'd4;
  localparam logic [3:0] FuncInt16  = 4'd5;
  localparam logic [3:0] FuncUint16 = 4'd6;
  localparam logic [3:0] FuncInt32  = 4'd7;
  localparam logic [3:0] FuncUint32 = 4'd8;
  localparam logic [3:0] FuncInt64  = 4'd9;
  localparam logic [3:0] FuncUint64 = 4'd10;
  localparam logic [3:0] FuncF32    = 4'd11;
  localparam logic [3:0] FuncF64    = 4'd12;

  localparam logic [7:0] PfxF32     = 8'hca;
  localparam logic [7:0] PfxF64     = 8'hcb;
  localparam logic [7:0] PfxUint8   = 8'hcc;
  localparam logic [7:0] PfxUint16  = 8'hcd;
  localparam logic [7:0] PfxUint32  = 8'hce;
  localparam logic [7:0] PfxUint64  = 8'hcf;
  localparam logic [7:0] PfxInt8    = 8'hd0;
  localparam logic [7:0] PfxInt16   = 8'hd1;
  localparam logic [7:0] PfxInt32   = 8'hd2;
  localparam logic [7:0] PfxInt64   = 8'hd3;
  localparam logic [7:0] PfxNegLow  = 8'he0;
  localparam logic [7:0] PfxFixStr  = 8'ha0;
  localparam logic [7:0] PfxFixStrE = 8'hbf;
  localparam logic [7:0] PfxStr8    = 8'hd9;
  localparam logic [7:0] PfxStr16   = 8'hda;
  localparam logic [7:0] PfxStr32   = 8'hdb;
  localparam logic [7:0] FixStrMask = 8'h1f;

  localparam logic [63:0] NanBits = 64'h7FF8_0000_0000_0000;

endpackage

// File: rtl/core/typed_value_stream_decoder.sv
// Top level of the typed value stream decoder.
// The block takes an encoded byte stream, one byte per input transaction on
// in_byte_i, with the expected type on func_i sampled at the first byte of
// each value. Numbers carry a prefix (fixint, uint and int of 8 to 64 bits,
// float of 32 or 64 bits), fixed-width types gather 1 to 8 little-endian
// bytes, and strings give a length result, then one result per data byte.
// Each output transaction carries value_bits_o, value_kind_o and is_last_o.
// A byte that yields a result shows it in the cycle after its transaction,
// from the output register; only the last payload or length byte gives one.
// One byte is accepted in every cycle: the decode of a byte is a prefix
// compare or a byte-lane write into the assembly register, done in the
// cycle of its transaction. in_ready_o is low only while a result waits in
// the output register and out_ready_i is low; then the input side stalls.
// Reset returns the decoder to the start of a value and empties the output
// register.
module typed_value_stream_decoder
  import tvsd_pkg::*;
#(
  parameter int LengthBits = LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic [3:0]  func_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_bits_o,
  output logic [2:0]  value_kind_o,
  output logic        is_last_o
);

`include "typed_value_stream_decoder_assert.svh"

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhPayload = 2'd1,
    PhStrLen  = 2'd2,
    PhStrData = 2'd3
  } phase_e;

  localparam logic [31:0] LenMax = 32'((64'd1 << LengthBits) - 64'd1);

  phase_e                  phase_q, phase_d;
  logic [3:0]              bytes_left_q, bytes_left_d;
  logic [2:0]              byte_pos_q, byte_pos_d;
  logic [63:0]             assembly_q, assembly_d;
  kind_e                   pending_kind_q, pending_kind_d;
  logic [LengthBits-1:0]   string_left_q, string_left_d;

  logic                    out_valid_q;
  logic [63:0]             out_bits_q;
  kind_e                   out_kind_q;
  logic                    out_last_q;

  logic                    take;
  logic                    emit;
  logic [63:0]             res_bits;
  kind_e                   res_kind;
  logic                    res_last;

  logic [63:0]             asm_or;
  logic [63:0]             asm_sext;
  logic                    asm_sign;

  logic                    str_go;
  logic [31:0]             str_len;
  logic                    fix_go;
  logic [3:0]              fix_n;
  kind_e                   fix_kind;
  logic                    num_go;
  logic [3:0]              num_n;
  kind_e                   num_kind;

  assign in_ready_o   = !out_valid_q || out_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign value_bits_o = out_bits_q;
  assign value_kind_o = out_kind_q;
  assign is_last_o    = out_last_q;

  always_comb begin
    asm_or = assembly_q;
    for (int i = 0; i < 8; i++) begin
      if (byte_pos_q == 3'(i)) begin
        asm_or[8*i +: 8] = assembly_q[8*i +: 8] | in_byte_i;
      end
    end
  end

  assign asm_sign = asm_or[{byte_pos_q, 3'd7}];

  always_comb begin
    asm_sext = asm_or;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) > byte_pos_q) begin
        asm_sext[8*i +: 8] = {8{asm_sign}};
      end
    end
  end

  always_comb begin
    phase_d        = phase_q;
    bytes_left_d   = bytes_left_q;
    byte_pos_d     = byte_pos_q;
    assembly_d     = assembly_q;
    pending_kind_d = pending_kind_q;
    string_left_d  = string_left_q;
    emit           = 1'b0;
    res_bits       = '0;
    res_kind       = KUnsigned;
    res_last       = 1'b0;
    str_go         = 1'b0;
    str_len        = '0;
    fix_go         = 1'b0;
    fix_n          = 4'd1;
    fix_kind       = KUnsigned;
    num_go         = 1'b0;
    num_n          = 4'd1;
    num_kind       = KUnsigned;

    if (take) begin
      unique case (phase_q)
        PhPayload, PhStrLen: begin
          assembly_d = asm_or;
          if (bytes_left_q <= 4'd1) begin
            if (phase_q == PhStrLen) begin
              str_go  = 1'b1;
              str_len = asm_or[31:0];
            end else begin
              emit         = 1'b1;
              res_bits     = (pending_kind_q == KSigned) ? asm_sext : asm_or;
              res_kind     = pending_kind_q;
              res_last     = 1'b1;
              phase_d      = PhIdle;
              bytes_left_d = '0;
              byte_pos_d   = '0;
            end
          end else begin
            bytes_left_d = bytes_left_q - 4'd1;
            byte_pos_d   = byte_pos_q + 3'd1;
          end
        end
        PhStrData: begin
          emit     = 1'b1;
          res_bits = 64'(in_byte_i);
          res_kind = KStrByte;
          if (string_left_q <= LengthBits'(1)) begin
            res_last      = 1'b1;
            string_left_d = '0;
            phase_d       = PhIdle;
          end else begin
            string_left_d = string_left_q - LengthBits'(1);
          end
        end
        PhIdle: begin
          unique case (func_i)
            FuncNumber: begin
              if (in_byte_i < 8'h80) begin
                emit     = 1'b1;
                res_bits = 64'(in_byte_i);
                res_kind = KUnsigned;
                res_last = 1'b1;
              end else if (in_byte_i >= PfxNegLow) begin
                emit     = 1'b1;
                res_bits = {56'hFF_FFFF_FFFF_FFFF, in_byte_i};
                res_kind = KSigned;
                res_last = 1'b1;
              end else begin
                num_go = 1'b1;
                unique case (in_byte_i)
                  PfxF32:    begin num_n = 4'd4; num_kind = KF32;      end
                  PfxF64:    begin num_n = 4'd8; num_kind = KF64;      end
                  PfxUint8:  begin num_n = 4'd1; num_kind = KUnsigned; end
                  PfxUint16: begin num_n = 4'd2; num_kind = KUnsigned; end
                  PfxUint32: begin num_n = 4'd4; num_kind = KUnsigned; end
                  PfxUint64: begin num_n = 4'd8; num_kind = KUnsigned; end
                  PfxInt8:   begin num_n = 4'd1; num_kind = KSigned;   end
                  PfxInt16:  begin num_n = 4'd2; num_kind = KSigned;   end
                  PfxInt32:  begin num_n = 4'd4; num_kind = KSigned;   end
                  PfxInt64:  begin num_n = 4'd8; num_kind = KSigned;   end
                  default: begin
                    num_go   = 1'b0;
                    emit     = 1'b1;
                    res_bits = NanBits;
                    res_kind = KNan;
                    res_last = 1'b1;
                  end
                endcase
              end
            end
            FuncString: begin
              if (in_byte_i >= PfxFixStr && in_byte_i <= PfxFixStrE) begin
                str_go  = 1'b1;
                str_len = 32'(in_byte_i & FixStrMask);
              end else if (in_byte_i < 8'h80) begin
                str_go  = 1'b1;
                str_len = 32'(in_byte_i);
              end else if (in_byte_i == PfxStr8 || in_byte_i == PfxUint8) begin
                phase_d      = PhStrLen;
                bytes_left_d = 4'd1;
                byte_pos_d   = '0;
                assembly_d   = '0;
              end else if (in_byte_i == PfxStr16 || in_byte_i == PfxUint16) begin
                phase_d      = PhStrLen;
                bytes_left_d = 4'd2;
                byte_pos_d   = '0;
                assembly_d   = '0;
              end else if (in_byte_i == PfxStr32) begin
                phase_d      = PhStrLen;
                bytes_left_d = 4'd4;
                byte_pos_d   = '0;
                assembly_d   = '0;
              end else begin
                str_go  = 1'b1;
                str_len = '0;
              end
            end
            FuncBool: begin
              emit     = 1'b1;
              res_bits = 64'(in_byte_i != 8'd0);
              res_kind = KBool;
              res_last = 1'b1;
            end
            FuncInt8:   begin fix_go = 1'b1; fix_n = 4'd1; fix_kind = KSigned;   end
            FuncUint8:  begin fix_go = 1'b1; fix_n = 4'd1; fix_kind = KUnsigned; end
            FuncInt16:  begin fix_go = 1'b1; fix_n = 4'd2; fix_kind = KSigned;   end
            FuncUint16: begin fix_go = 1'b1; fix_n = 4'd2; fix_kind = KUnsigned; end
            FuncInt32:  begin fix_go = 1'b1; fix_n = 4'd4; fix_kind = KSigned;   end
            FuncUint32: begin fix_go = 1'b1; fix_n = 4'd4; fix_kind = KUnsigned; end
            FuncInt64:  begin fix_go = 1'b1; fix_n = 4'd8; fix_kind = KSigned;   end
            FuncUint64: begin fix_go = 1'b1; fix_n = 4'd8; fix_kind = KUnsigned; end
            FuncF32:    begin fix_go = 1'b1; fix_n = 4'd4; fix_kind = KF32;      end
            FuncF64:    begin fix_go = 1'b1; fix_n = 4'd8; fix_kind = KF64;      end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase

      if (num_go) begin
        phase_d        = PhPayload;
        pending_kind_d = num_kind;
        bytes_left_d   = num_n;
        byte_pos_d     = '0;
        assembly_d     = '0;
      end

      if (fix_go) begin
        pending_kind_d = fix_kind;
        assembly_d     = 64'(in_byte_i);
        if (fix_n <= 4'd1) begin
          emit     = 1'b1;
          res_bits = (fix_kind == KSigned) ? {{56{in_byte_i[7]}}, in_byte_i}
                                           : 64'(in_byte_i);
          res_kind = fix_kind;
          res_last = 1'b1;
        end else begin
          phase_d      = PhPayload;
          bytes_left_d = fix_n - 4'd1;
          byte_pos_d   = 3'd1;
        end
      end

      if (str_go) begin
        if (str_len > LenMax) begin
          str_len = LenMax;
        end
        bytes_left_d = '0;
        byte_pos_d   = '0;
        assembly_d   = '0;
        emit         = 1'b1;
        res_bits     = 64'(str_len);
        res_kind     = KStrLen;
        if (str_len == 32'd0) begin
          res_last      = 1'b1;
          phase_d       = PhIdle;
          string_left_d = '0;
        end else begin
          phase_d       = PhStrData;
          string_left_d = str_len[LengthBits-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      bytes_left_q   <= '0;
      byte_pos_q     <= '0;
      assembly_q     <= '0;
      pending_kind_q <= KUnsigned;
      string_left_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      bytes_left_q   <= bytes_left_d;
      byte_pos_q     <= byte_pos_d;
      assembly_q     <= assembly_d;
      pending_kind_q <= pending_kind_d;
      string_left_q  <= string_left_d;
      if (take) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_bits_q <= res_bits;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  `TVSD_ASSERT(payload_count_ok,
      phase_q == PhPayload |-> bytes_left_q != 4'd0 && bytes_left_q <= 4'd8,
      "payload phase with an impossible byte count")
  `TVSD_ASSERT(strdata_count_ok, phase_q == PhStrData |-> string_left_q != '0,
      "string data phase with no bytes left")
  `TVSD_ASSERT_IMPL(payload_silent,
      take && phase_q == PhPayload && bytes_left_q > 4'd1, !out_valid_q,
      "payload byte produced a result")
  `TVSD_ASSERT_IMPL(strdata_emits, take && phase_q == PhStrData,
      out_valid_q && out_kind_q == KStrByte,
      "string data byte did not produce a string byte result")
  `TVSD_ASSERT(open_length_in_data,
      out_valid_q && out_kind_q == KStrLen && !out_last_q |-> phase_q == PhStrData,
      "open string length result outside the string data phase")

endmodule

// File: tb/sv/tb_typed_value_stream_decoder.sv
// Self-checking testbench for the typed value stream decoder with a built-in predictor.
`timescale 1ns / 100ps

module tb_typed_value_stream_decoder;
  import tvsd_pkg::*;

  typedef enum logic [1:0] {
    DecStart,
    DecPayload,
    DecStrLen,
    DecStrData
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] func;
  } stream_byte_t;

  typedef struct packed {
    logic [63:0] bits;
    kind_e       kind;
    logic        last;
  } decoded_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic [3:0]  func_i = 4'h0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] value_bits_o;
  logic [2:0]  value_kind_o;
  logic        is_last_o;

  stream_byte_t pending_bytes[$];
  decoded_t     expected_values[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          stress_phase;
  bit          long_stall_done;
  int unsigned recv_hold;
  int unsigned mismatches;

  dec_phase_e  dec_phase;
  logic [3:0]  dec_type;
  logic [3:0]  dec_bytes_left;
  logic [2:0]  dec_pos;
  logic [63:0] dec_assembly;
  kind_e       dec_kind;
  logic [31:0] dec_str_left;

  typed_value_stream_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .func_i       (func_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_bits_o (value_bits_o),
    .value_kind_o (value_kind_o),
    .is_last_o    (is_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void number_format(input logic [7:0] p, output int n, output kind_e k);
    n = 0;
    k = KUnsigned;
    case (p)
      PfxF32:    begin n = 4; k = KF32;      end
      PfxF64:    begin n = 8; k = KF64;      end
      PfxUint8:  begin n = 1; k = KUnsigned; end
      PfxUint16: begin n = 2; k = KUnsigned; end
      PfxUint32: begin n = 4; k = KUnsigned; end
      PfxUint64: begin n = 8; k = KUnsigned; end
      PfxInt8:   begin n = 1; k = KSigned;   end
      PfxInt16:  begin n = 2; k = KSigned;   end
      PfxInt32:  begin n = 4; k = KSigned;   end
      PfxInt64:  begin n = 8; k = KSigned;   end
      default:   ;
    endcase
  endfunction

  function automatic void fixed_format(input logic [3:0] f, output int n, output kind_e k);
    n = 1;
    k = KUnsigned;
    case (f)
      FuncInt8:   begin n = 1; k = KSigned;   end
      FuncUint8:  begin n = 1; k = KUnsigned; end
      FuncInt16:  begin n = 2; k = KSigned;   end
      FuncUint16: begin n = 2; k = KUnsigned; end
      FuncInt32:  begin n = 4; k = KSigned;   end
      FuncUint32: begin n = 4; k = KUnsigned; end
      FuncInt64:  begin n = 8; k = KSigned;   end
      FuncUint64: begin n = 8; k = KUnsigned; end
      FuncF32:    begin n = 4; k = KF32;      end
      FuncF64:    begin n = 8; k = KF64;      end
      default:    ;
    endcase
  endfunction

  function automatic int str_len_bytes(input logic [7:0] p);
    case (p)
      PfxStr8, PfxUint8:   return 1;
      PfxStr16, PfxUint16: return 2;
      PfxStr32:            return 4;
      default:             return 0;
    endcase
  endfunction

  function automatic void expect_value(input logic [63:0] bits, input kind_e k, input logic last);
    expected_values.push_back('{bits, k, last});
  endfunction

  function automatic void complete_payload(input int nbytes);
    logic [63:0] v;
    v = dec_assembly;
    dec_phase = DecStart;
    dec_bytes_left = '0;
    dec_pos = '0;
    if (dec_kind == KSigned && nbytes < 8) begin
      v &= (64'd1 << (8 * nbytes)) - 64'd1;
      if (v[8 * nbytes - 1]) v |= ~64'd0 << (8 * nbytes);
    end
    expect_value(v, dec_kind, 1'b1);
  endfunction

  function automatic void open_string(input logic [63:0] len);
    logic [63:0] max_len;
    max_len = (64'd1 << LengthBitsDefault) - 64'd1;
    if (len > max_len) len = max_len;
    dec_bytes_left = '0;
    dec_pos = '0;
    dec_assembly = '0;
    if (len == 0) begin
      dec_phase = DecStart;
      dec_str_left = '0;
      expect_value(64'd0, KStrLen, 1'b1);
    end else begin
      dec_str_left = len[31:0];
      dec_phase = DecStrData;
      expect_value(len, KStrLen, 1'b0);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic [3:0] f);
    int    n;
    int    pos;
    kind_e k;
    if (dec_phase == DecPayload || dec_phase == DecStrLen) begin
      pos = dec_pos;
      dec_assembly |= 64'(b) << (8 * pos);
      if (dec_bytes_left <= 1) begin
        if (dec_phase == DecStrLen) open_string(dec_assembly);
        else complete_payload(pos + 1);
      end else begin
        dec_bytes_left = dec_bytes_left - 1;
        dec_pos = 3'(pos + 1);
      end
    end else if (dec_phase == DecStrData) begin
      if (dec_str_left <= 1) begin
        dec_str_left = '0;
        dec_phase = DecStart;
        expect_value(64'(b), KStrByte, 1'b1);
      end else begin
        dec_str_left = dec_str_left - 1;
        expect_value(64'(b), KStrByte, 1'b0);
      end
    end else if (f <= FuncF64) begin
      dec_type = f;
      if (f == FuncNumber) begin
        number_format(b, n, k);
        if (b < 8'h80) begin
          expect_value(64'(b), KUnsigned, 1'b1);
        end else if (b >= PfxNegLow) begin
          expect_value({56'hFF_FFFF_FFFF_FFFF, b}, KSigned, 1'b1);
        end else if (n == 0) begin
          expect_value(NanBits, KNan, 1'b1);
        end else begin
          dec_phase = DecPayload;
          dec_kind = k;
          dec_bytes_left = 4'(n);
          dec_pos = '0;
          dec_assembly = '0;
        end
      end else if (f == FuncString) begin
        n = str_len_bytes(b);
        if (b >= PfxFixStr && b <= PfxFixStrE) begin
          open_string(64'(b & FixStrMask));
        end else if (b < 8'h80) begin
          open_string(64'(b));
        end else if (n == 0) begin
          open_string(64'd0);
        end else begin
          dec_phase = DecStrLen;
          dec_bytes_left = 4'(n);
          dec_pos = '0;
          dec_assembly = '0;
        end
      end else if (f == FuncBool) begin
        expect_value((b != 8'h00) ? 64'd1 : 64'd0, KBool, 1'b1);
      end else begin
        fixed_format(f, n, k);
        dec_kind = k;
        dec_assembly = 64'(b);
        if (n <= 1) begin
          complete_payload(1);
        end else begin
          dec_phase = DecPayload;
          dec_bytes_left = 4'(n - 1);
          dec_pos = 3'd1;
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    logic         offer;
    stream_byte_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      dec_phase = DecStart;
      dec_type = '0;
      dec_bytes_left = '0;
      dec_pos = '0;
      dec_assembly = '0;
      dec_kind = KUnsigned;
      dec_str_left = '0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        decode_byte(in_byte_i, func_i);
        offer = 1'b0;
      end
      if (!offer && pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_bytes.pop_front();
        in_byte_i <= item.data;
        func_i <= item.func;
        offer = 1'b1;
      end
      in_valid_i <= offer;
    end
  end

  always @(posedge clk_i) begin
    decoded_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_hold <= 0;
      long_stall_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_values.size() == 0) begin
          $error("unexpected output transaction: value_bits %h, value_kind %0d, is_last %0b",
                 value_bits_o, value_kind_o, is_last_o);
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          if (value_bits_o !== want.bits) begin
            $error("value_bits: expected %h, actual %h", want.bits, value_bits_o);
            mismatches++;
          end
          if (value_kind_o !== want.kind) begin
            $error("value_kind: expected %0d, actual %0d", want.kind, value_kind_o);
            mismatches++;
          end
          if (is_last_o !== want.last) begin
            $error("is_last: expected %0b, actual %0b", want.last, is_last_o);
            mismatches++;
          end
        end
      end
      if (recv_hold != 0) begin
        recv_hold <= recv_hold - 1;
        out_ready_i <= 1'b0;
      end else if (stress_phase && !long_stall_done && out_valid_o) begin
        recv_hold <= 300;
        long_stall_done <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void queue_byte(input logic [7:0] data, input logic [3:0] func);
    pending_bytes.push_back('{data, func});
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [3:0] any_func();
    return 4'($urandom_range(15));
  endfunction

  // Queues one complete value and reports how many accepted bytes it uses.
  function automatic int queue_value();
    logic [3:0]  f;
    logic [7:0]  p;
    logic [31:0] len;
    int          n;
    int          count;
    kind_e       k;
    if ($urandom_range(99) < 4) begin
      queue_byte(any_byte(), 4'($urandom_range(13, 15)));
      return 0;
    end
    f = 4'($urandom_range(12));
    count = 1;
    if (f == FuncNumber) begin
      p = $urandom_range(1) ? 8'(PfxF32 + $urandom_range(9)) : any_byte();
      number_format(p, n, k);
      if (p < 8'h80 || p >= PfxNegLow) n = 0;
      queue_byte(p, f);
      for (int i = 0; i < n; i++) queue_byte(any_byte(), any_func());
      count += n;
    end else if (f == FuncString) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(12);
      case ($urandom_range(9))
        0, 1, 2, 8, 9: begin
          len = len & 32'h1f;
          queue_byte(PfxFixStr | 8'(len), f);
        end
        3: begin
          len = len & 32'h7f;
          queue_byte(8'(len), f);
        end
        4: begin
          if ($urandom_range(9) == 0) len = $urandom_range(255);
          queue_byte($urandom_range(1) ? PfxStr8 : PfxUint8, f);
          queue_byte(8'(len), any_func());
          count += 1;
        end
        5: begin
          if ($urandom_range(9) == 0) len = $urandom_range(300);
          queue_byte($urandom_range(1) ? PfxStr16 : PfxUint16, f);
          queue_byte(len[7:0], any_func());
          queue_byte(len[15:8], any_func());
          count += 2;
        end
        6: begin
          queue_byte(PfxStr32, f);
          for (int i = 0; i < 4; i++) queue_byte(len[8 * i +: 8], any_func());
          count += 4;
        end
        default: begin
          do begin
            p = 8'($urandom_range(128, 255));
          end while ((p >= PfxFixStr && p <= PfxFixStrE) || str_len_bytes(p) != 0);
          queue_byte(p, f);
          len = 0;
        end
      endcase
      for (int i = 0; i < len; i++) queue_byte(any_byte(), any_func());
      count += len;
    end else if (f == FuncBool) begin
      queue_byte(($urandom_range(3) == 0) ? 8'h00 : any_byte(), f);
    end else begin
      fixed_format(f, n, k);
      queue_byte(any_byte(), f);
      for (int i = 1; i < n; i++) queue_byte(any_byte(), any_func());
      count += n - 1;
    end
    return count;
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || expected_values.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int made;
    mismatches = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stress_phase = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_byte(8'h00, FuncNumber);
    queue_byte(8'h7f, FuncNumber);
    queue_byte(PfxNegLow, FuncNumber);
    queue_byte(8'hff, FuncNumber);
    queue_byte(8'hc1, FuncNumber);
    queue_byte(PfxUint8, FuncNumber);
    queue_byte(8'hff, FuncF64);
    queue_byte(PfxInt8, FuncNumber);
    queue_byte(8'h80, FuncNumber);
    queue_byte(PfxF32, FuncNumber);
    queue_byte(8'h00, FuncBool);
    queue_byte(8'h00, FuncBool);
    queue_byte(8'h80, 4'hf);
    queue_byte(8'hbf, 4'hf);
    queue_byte(8'h55, 4'hf);
    queue_byte(8'h00, FuncBool);
    queue_byte(8'h80, FuncBool);
    queue_byte(PfxFixStr, FuncString);
    queue_byte(8'hc1, FuncString);
    queue_byte(PfxStr8, FuncString);
    queue_byte(8'h01, FuncNumber);
    queue_byte(8'hff, FuncNumber);
    queue_byte(8'h80, FuncInt8);
    queue_byte(8'hff, FuncUint8);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 27 : 0;
      stress_phase = (ph == 2);
      made = 0;
      while (made < 510) made += queue_value();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
